// ----- rtl/core/u16u8_pkg.sv -----
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types and constants for the UTF-16 to UTF-8 encoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

   localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;
   localparam logic        STATUS_OK      = 1'b0;
   localparam logic        STATUS_OVERFLOW = 1'b1;

   localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
   localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;
   localparam logic [5:0]  HI_SURR_TAG    = 6'b110110;
   localparam logic [5:0]  LO_SURR_TAG    = 6'b110111;
   localparam logic [10:0] SUPP_PLANE_OFS = 11'h040;
   localparam logic [7:0]  LEAD_2         = 8'hC0;
   localparam logic [7:0]  LEAD_3         = 8'hE0;
   localparam logic [7:0]  LEAD_4         = 8'hF0;
   localparam logic [7:0]  CONT_MARK      = 8'h80;

   // Per-string encoder state.
   typedef struct packed {
      logic [9:0]  held;
      logic        pend;
      logic [15:0] cnt;
      logic        drop;
   } state_type;

   // All result beats caused by one code unit.
   typedef struct packed {
      logic [5:0][7:0] bytes;
      logic [2:0]      num;
      logic            ovf;
      logic            eos;
      logic [15:0]     cnt;
   } job_type;

endpackage

// ----- rtl/core/u16u8_step.sv -----
// ----------------------------------------------------------------------------
// u16u8_step
// Encodes one code unit against the current string state: builds the byte
// groups, checks them against the capacity and gives the next state.
// ----------------------------------------------------------------------------
module u16u8_step
   import u16u8_pkg::*;
(
   input  logic [15:0] code_unit,
   input  logic        last_unit,
   input  logic [15:0] capacity,
   input  state_type   cur,
   output state_type   state_in,
   output job_type     job_in
);

   typedef struct packed {
      logic [3:0][7:0] b;
      logic [2:0]      len;
   } grp_type;

   function automatic grp_type encode_bmp(input logic [15:0] u);
      grp_type g;
      g = '0;
      if (u < ONE_BYTE_LIMIT) begin
         g.b[0] = u[7:0];
         g.len  = 3'd1;
      end else if (u < TWO_BYTE_LIMIT) begin
         g.b[0] = LEAD_2 | {3'b000, u[10:6]};
         g.b[1] = CONT_MARK | {2'b00, u[5:0]};
         g.len  = 3'd2;
      end else begin
         g.b[0] = LEAD_3 | {4'b0000, u[15:12]};
         g.b[1] = CONT_MARK | {2'b00, u[11:6]};
         g.b[2] = CONT_MARK | {2'b00, u[5:0]};
         g.len  = 3'd3;
      end
      return g;
   endfunction

   logic        is_hi;
   logic        is_lo;
   logic        pair;
   logic        hold;
   logic [20:0] cp;
   grp_type     g0;
   grp_type     g1;
   logic [16:0] sum0;
   logic [16:0] sum1;
   logic        ovf0;
   logic        ovf1;

   assign is_hi = code_unit[15:10] == HI_SURR_TAG;
   assign is_lo = code_unit[15:10] == LO_SURR_TAG;
   assign pair  = cur.pend && is_lo;
   assign hold  = !pair && is_hi && !last_unit;
   assign cp    = {11'(cur.held) + SUPP_PLANE_OFS, code_unit[9:0]};

   always_comb begin
      g0 = '0;
      if (pair) begin
         g0.b[0] = LEAD_4 | {5'b00000, cp[20:18]};
         g0.b[1] = CONT_MARK | {2'b00, cp[17:12]};
         g0.b[2] = CONT_MARK | {2'b00, cp[11:6]};
         g0.b[3] = CONT_MARK | {2'b00, cp[5:0]};
         g0.len  = 3'd4;
      end else if (cur.pend) begin
         // flush the unpaired high surrogate in 3-byte form
         g0 = encode_bmp({HI_SURR_TAG, cur.held});
      end
   end

   assign g1 = (pair || hold) ? grp_type'('0) : encode_bmp(code_unit);

   // one byte of the capacity stays free for the terminator
   assign sum0 = {1'b0, cur.cnt} + 17'(g0.len);
   assign sum1 = sum0 + 17'(g1.len);
   assign ovf0 = (g0.len != 3'd0) && !(sum0 < {1'b0, capacity});
   assign ovf1 = !ovf0 && (g1.len != 3'd0) && !(sum1 < {1'b0, capacity});

   always_comb begin
      case (g0.len)
         3'd3:    job_in.bytes = {g1.b[2:0], g0.b[2:0]};
         3'd4:    job_in.bytes = {16'h0000, g0.b};
         default: job_in.bytes = {16'h0000, g1.b};
      endcase

      job_in.ovf = !cur.drop && (ovf0 || ovf1);
      job_in.eos = job_in.ovf || last_unit;
      job_in.cnt = cur.cnt;
      if (cur.drop) begin
         job_in.num = 3'd0;
      end else if (ovf0) begin
         job_in.num = 3'd1;
      end else if (ovf1) begin
         job_in.num = g0.len + 3'd1;
      end else begin
         job_in.num = g0.len + g1.len;
      end

      state_in = cur;
      if (cur.drop) begin
         state_in.drop = !last_unit;
      end else if (ovf0 || ovf1) begin
         state_in      = '0;
         state_in.drop = !last_unit;
      end else if (last_unit) begin
         state_in = '0;
      end else begin
         state_in.cnt  = sum1[15:0];
         state_in.pend = hold;
         if (hold) begin
            state_in.held = code_unit[9:0];
         end
      end
   end

endmodule

// ----- rtl/core/utf16_to_utf8_encoder.sv -----
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder
// Streams UTF-16 code units in and UTF-8 bytes out, one byte per beat.
// ----------------------------------------------------------------------------
// Each accepted code unit yields its UTF-8 bytes as separate result beats:
// one to three for a BMP unit, four for a surrogate pair (the high surrogate
// is held until the next unit), and up to six when an unpaired high is
// flushed ahead of the next unit. A running count is checked against
// csr_wr_data's capacity with one byte kept for a terminator; a group that
// does not fit ends the string with one overflow beat (byte 0, status 1) and
// the rest of that string is dropped. Throughput is set by the byte-wide
// result register: a unit occupies it one cycle per beat it produces while
// rsp_tready is high, so plain ASCII runs at one unit a cycle; units that
// yield nothing (held or dropped) emit no beat, and a longer group holds the
// next unit back until its last beat is loaded. A result beat passes through
// the input, beat-list and result registers before it is presented.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder
   import u16u8_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,   // dest_capacity

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,     // [15:0] code_unit
   input  logic        req_tlast,     // last_unit

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,     // [7:0] out_byte, [23:8] bytes_written
   output logic        rsp_tlast,     // end_of_string
   output logic        rsp_tuser      // status
);

   logic [15:0] capacity_ff;

   logic        in_valid_ff;
   logic [15:0] in_unit_ff;
   logic        in_last_ff;

   state_type   state_ff;
   state_type   state_in;
   job_type     job_in;

   logic        job_valid_ff;
   job_type     job_ff;
   logic [2:0]  job_idx_ff;
   logic [15:0] job_cnt_ff;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_byte_ff;
   logic [15:0] rsp_count_ff;
   logic        rsp_last_ff;
   logic        rsp_status_ff;

   logic        out_load;
   logic        final_beat;
   logic        ovf_beat;
   logic        job_free;
   logic        in_take;

   u16u8_step u_step (
      .code_unit (in_unit_ff),
      .last_unit (in_last_ff),
      .capacity  (capacity_ff),
      .cur       (state_ff),
      .state_in  (state_in),
      .job_in    (job_in)
   );

   assign out_load   = job_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign final_beat = job_idx_ff == (job_ff.num - 3'd1);
   assign ovf_beat   = job_ff.ovf && final_beat;
   assign job_free   = !job_valid_ff || (out_load && final_beat);
   assign in_take    = in_valid_ff && job_free;
   assign req_tready = !in_valid_ff || in_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_unit_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // string state and the beat list of the unit being emitted
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         job_valid_ff <= 1'b0;
      end else begin
         if (in_take) begin
            state_ff     <= state_in;
            job_valid_ff <= job_in.num != 3'd0;
         end else if (out_load && final_beat) begin
            job_valid_ff <= 1'b0;
         end
      end
      if (in_take) begin
         job_ff     <= job_in;
         job_idx_ff <= 3'd0;
         job_cnt_ff <= job_in.cnt;
      end else if (out_load) begin
         job_idx_ff <= job_idx_ff + 3'd1;
         job_cnt_ff <= job_cnt_ff + 16'd1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_byte_ff   <= ovf_beat ? 8'h00 : job_ff.bytes[job_idx_ff];
         rsp_count_ff  <= ovf_beat ? job_cnt_ff : job_cnt_ff + 16'd1;
         rsp_last_ff   <= final_beat && job_ff.eos;
         rsp_status_ff <= ovf_beat ? STATUS_OVERFLOW : STATUS_OK;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_byte_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

`ifndef SYNTHESIS
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff |-> job_idx_ff < job_ff.num)
      else $error("beat index past end of beat list");

   a_drop_clean: assert property (@(posedge clock) disable iff (reset)
      state_ff.drop |-> !state_ff.pend && state_ff.cnt == 16'd0)
      else $error("dropping string still holds count or surrogate");

   a_ovf_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_OVERFLOW |->
         rsp_last_ff && rsp_byte_ff == 8'h00)
      else $error("overflow beat does not end the string");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !in_take |=> in_valid_ff && $stable(in_unit_ff))
      else $error("stalled input unit lost");
`endif

endmodule
